// File: design/cht_pkg.sv
package cht_pkg;

  // table geometry
  localparam int NUM_TABLES      = 2;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SLOTS           = 1 << TABLE_ADDR_BITS;
  localparam int TABLE_SEL_BITS  = 1;

  // field widths
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int TAG_BITS   = 8;
  localparam int HASH_BITS  = 20;

  // hash extended so that every table slice exists; missing bits read as zero
  localparam int HASH_EXT_BITS = HASH_BITS + NUM_TABLES * TABLE_ADDR_BITS;

  // valid mark plus key as stored
  localparam int VKEY_BITS = KEY_BITS + 1;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  // slot probed in table t
  function automatic logic [TABLE_ADDR_BITS-1:0] hash_slice(
    input logic [HASH_BITS-1:0] hash,
    input int                   t
  );
    logic [HASH_EXT_BITS-1:0] ext;
    ext = HASH_EXT_BITS'(hash);
    return ext[t*TABLE_ADDR_BITS +: TABLE_ADDR_BITS];
  endfunction

endpackage

// File: design/cht_ram.sv
module cht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/cuckoo_hash_table_lookup.sv
// done strobes once a taken beat has passed the stage-one and result registers
// throughput: one lookup per cycle while busy is low; each table is its
// own memory, so the update write and all probes happen in the same cycle
// reset: a clearing pass over all 1024 slots (one slot of every table a cycle)
// holds busy high; the receiver cannot stall, so busy is high only then
module cuckoo_hash_table_lookup (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        update_valid,
  input  logic [0:0]  update_table,
  input  logic [9:0]  update_slot,
  input  logic        update_entry_valid,
  input  logic [31:0] update_key,
  input  logic [31:0] update_value,
  input  logic [19:0] lookup_hash,
  input  logic [31:0] lookup_key,
  input  logic [7:0]  lookup_tag,
  output logic        done,
  output logic        found,
  output logic [31:0] found_value,
  output logic [31:0] echo_key,
  output logic [19:0] echo_hash,
  output logic [7:0]  echo_tag
);

  localparam int NT = cht_pkg::NUM_TABLES;
  localparam int AB = cht_pkg::TABLE_ADDR_BITS;

  cht_pkg::state_t state, state_next;
  logic [AB-1:0]   clr_addr;
  logic            accept;
  logic            clearing;

  // stage one registers
  logic                              s1_valid;
  logic [cht_pkg::HASH_BITS-1:0]     s1_hash;
  logic [cht_pkg::KEY_BITS-1:0]      s1_key;
  logic [cht_pkg::TAG_BITS-1:0]      s1_tag;
  logic [NT-1:0]                     s1_fwd;
  logic                              s1_upd_vld;
  logic [cht_pkg::KEY_BITS-1:0]      s1_upd_key;
  logic [cht_pkg::VALUE_BITS-1:0]    s1_upd_value;

  logic [cht_pkg::VKEY_BITS-1:0]  rd_vkey  [NT];
  logic [cht_pkg::VALUE_BITS-1:0] rd_value [NT];

  logic                           hit;
  logic [cht_pkg::VALUE_BITS-1:0] hit_value;

  assign accept = start && !busy;

  // clear state and run state
  always_comb begin
    state_next = state;
    unique case (state)
      cht_pkg::ST_CLEAR: if (clr_addr == {AB{1'b1}}) state_next = cht_pkg::ST_RUN;
      cht_pkg::ST_RUN:   state_next = cht_pkg::ST_RUN;
      default:           state_next = cht_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    unique case (state)
      cht_pkg::ST_CLEAR: clearing = 1'b1;
      cht_pkg::ST_RUN:   clearing = 1'b0;
      default:           clearing = 1'b1;
    endcase
  end

  assign busy = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cht_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + AB'(1);
      end
    end
  end

  // one memory pair per table; update write and probe share the cycle
  for (genvar t = 0; t < NT; t++) begin : g_table
    logic          we;
    logic [AB-1:0] waddr;
    logic [cht_pkg::VKEY_BITS-1:0]  wvkey;
    logic [cht_pkg::VALUE_BITS-1:0] wvalue;

    always_comb begin
      if (clearing) begin
        we     = 1'b1;
        waddr  = clr_addr;
        wvkey  = '0;
        wvalue = '0;
      end else begin
        we     = accept && update_valid &&
                 (update_table == cht_pkg::TABLE_SEL_BITS'(t));
        waddr  = update_slot[AB-1:0];
        wvkey  = {update_entry_valid, update_key};
        wvalue = update_value;
      end
    end

    cht_ram #(
      .WIDTH(cht_pkg::VKEY_BITS),
      .DEPTH(cht_pkg::SLOTS)
    ) u_vkey (
      .clk  (clk),
      .we   (we),
      .waddr(waddr),
      .wdata(wvkey),
      .raddr(cht_pkg::hash_slice(lookup_hash, t)),
      .rdata(rd_vkey[t])
    );

    cht_ram #(
      .WIDTH(cht_pkg::VALUE_BITS),
      .DEPTH(cht_pkg::SLOTS)
    ) u_value (
      .clk  (clk),
      .we   (we),
      .waddr(waddr),
      .wdata(wvalue),
      .raddr(cht_pkg::hash_slice(lookup_hash, t)),
      .rdata(rd_value[t])
    );
  end

  // capture lookup and note where the same-beat update hits a probed slot
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_hash      <= lookup_hash;
    s1_key       <= lookup_key;
    s1_tag       <= lookup_tag;
    s1_upd_vld   <= update_entry_valid;
    s1_upd_key   <= update_key;
    s1_upd_value <= update_value;
    for (int t = 0; t < NT; t++) begin
      s1_fwd[t] <= update_valid &&
                   (update_table == cht_pkg::TABLE_SEL_BITS'(t)) &&
                   (update_slot[AB-1:0] == cht_pkg::hash_slice(lookup_hash, t));
    end
  end

  // compare every table, highest-numbered match wins
  always_comb begin
    logic                           e_vld;
    logic [cht_pkg::KEY_BITS-1:0]   e_key;
    logic [cht_pkg::VALUE_BITS-1:0] e_value;
    hit       = 1'b0;
    hit_value = '0;
    for (int t = 0; t < NT; t++) begin
      if (s1_fwd[t]) begin
        e_vld   = s1_upd_vld;
        e_key   = s1_upd_key;
        e_value = s1_upd_value;
      end else begin
        e_vld   = rd_vkey[t][cht_pkg::KEY_BITS];
        e_key   = rd_vkey[t][cht_pkg::KEY_BITS-1:0];
        e_value = rd_value[t];
      end
      if (e_vld && (e_key == s1_key)) begin
        hit       = 1'b1;
        hit_value = e_value;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
    found       <= hit;
    found_value <= hit_value;
    echo_key    <= s1_key;
    echo_hash   <= s1_hash;
    echo_tag    <= s1_tag;
  end

`ifndef ASSERT_OFF
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("result without an accepted beat");

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !done && !s1_valid)
    else $error("result during clearing pass");

  a_miss_value_zero: assert property (@(posedge clk) disable iff (rst)
    done && !found |-> found_value == '0)
    else $error("miss with nonzero value");

  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    clearing && (clr_addr == {AB{1'b1}}) |=> !busy)
    else $error("clearing pass did not end");
`endif

endmodule
